// ===== hw/rtl/rpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;

  localparam int StackDepth = 128;
  localparam int PtrW = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);
  localparam int DataW = 64;
  localparam int CntW = 7;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_t;

  localparam logic [3:0] ErrUnder = 4'b0001;
  localparam logic [3:0] ErrOver  = 4'b0010;
  localparam logic [3:0] ErrDiv0  = 4'b0100;
  localparam logic [3:0] ErrBadOp = 4'b1000;

  localparam logic [63:0] QMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QMin = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POPR,
    ST_POPL,
    ST_LATCH,
    ST_SERIAL,
    ST_FINISH,
    ST_PUSH,
    ST_EOLRD,
    ST_EOLWAIT,
    ST_DONE
  } state_t;

  // two's complement magnitude
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  // sign plus magnitude to saturated Q31.32
  function automatic logic [63:0] sat64(input logic neg, input logic over,
                                        input logic [63:0] m);
    if (neg) sat64 = (over || m > QMin) ? QMin : (64'd0 - m);
    else     sat64 = (over || m > QMax) ? QMax : m;
  endfunction

  // integer part truncated toward zero, modulo 2^32
  function automatic logic [31:0] trunc32(input logic [63:0] v);
    logic [63:0] ip;
    ip = mag64(v) >> 32;
    trunc32 = v[63] ? 32'(64'd0 - ip) : ip[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rpn_stack_calculator_top.sv =====
// Channel  | Ports                                         | Handshake
// command  | opcode, number, end_of_line                   | start & !busy
// result   | report_valid, report_value, error_flags       | done, one cycle
//
// From the accepting edge to the done strobe: push writes the stack; add and
// subtract pop both operands and push the result; an unrecognized op or zero
// divisor ends early; end_of_line adds a pop for the report. Multiply, divide
// and modulo add a serial phase and a finish state: one product or quotient bit
// a cycle through the shared shift-add/subtract datapath. Stack memory reads are
// registered. busy drops the cycle after done; the next word is taken then.
// rst is synchronous; stack contents need no reset. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_calculator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [63:0] number,
  input  wire logic        end_of_line,
  output logic             done,
  output logic             report_valid,
  output logic [63:0]      report_value,
  output logic [3:0]       error_flags
);
  import rpn_pkg::*;

  logic [DataW-1:0] mem [StackDepth];
  logic [DataW-1:0] rd_data;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [DataW-1:0] wr_data;

  state_t state, state_next;
  logic [PtrW-1:0] sp, sp_next;
  logic [2:0]  op;
  logic        eol;
  logic [3:0]  err, err_next;
  logic [63:0] rgt, rgt_next, lft, lft_next;
  logic        rgt_ok, rgt_ok_next;
  // serial datapath: acc (remainder / product high), sh (quotient / multiplier)
  logic [63:0] acc, acc_next, sh, sh_next, dvs, dvs_next;
  logic        ovf, ovf_next;
  logic [CntW:0] cnt, cnt_next;
  logic [63:0] res, res_next;
  logic [63:0] rv, rv_next;
  logic        rv_ok, rv_ok_next;

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[sp[AddrW-1:0]] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp    <= '0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
    end
    op <= (state == ST_IDLE && start) ? opcode : op;
    eol <= (state == ST_IDLE && start) ? end_of_line : eol;
    err <= err_next;
    rgt <= rgt_next;
    lft <= lft_next;
    rgt_ok <= rgt_ok_next;
    acc <= acc_next;
    sh <= sh_next;
    dvs <= dvs_next;
    ovf <= ovf_next;
    cnt <= cnt_next;
    res <= res_next;
    rv <= rv_next;
    rv_ok <= rv_ok_next;
  end

  logic [64:0] sum65;
  logic [64:0] rem65;
  logic [63:0] mr;
  logic [31:0] td;
  logic [63:0] s64;

  always_comb begin
    state_next = state;
    sp_next = sp;
    err_next = err;
    rgt_next = rgt;
    lft_next = lft;
    rgt_ok_next = rgt_ok;
    acc_next = acc;
    sh_next = sh;
    dvs_next = dvs;
    ovf_next = ovf;
    cnt_next = cnt;
    res_next = res;
    rv_next = rv;
    rv_ok_next = rv_ok;
    wr_en = 1'b0;
    wr_data = res;
    rd_addr = AddrW'(sp - PtrW'(1));
    busy = (state != ST_IDLE);
    done = 1'b0;
    mr = mag64(rgt);
    td = trunc32(rgt);
    sum65 = '0;
    rem65 = '0;
    s64 = '0;

    unique case (state)
      ST_IDLE: begin
        err_next = '0;
        rv_next = '0;
        if (start) begin
          unique case (opcode) inside
            OP_PUSH: begin
              res_next = number;
              state_next = ST_PUSH;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: state_next = ST_POPR;
            default: begin
              err_next = ErrBadOp;
              state_next = ST_EOLRD;
            end
          endcase
        end
      end
      // pop right operand; data arrives next cycle
      ST_POPR: begin
        if (sp != '0) begin
          sp_next = sp - PtrW'(1);
          rgt_ok_next = 1'b1;
        end else begin
          rgt_ok_next = 1'b0;
          err_next = err | ErrUnder;
        end
        state_next = ST_POPL;
      end
      ST_POPL: begin
        s64 = rgt_ok ? rd_data : 64'd0;
        rgt_next = s64;
        if ((op == OP_DIV && s64 == 64'd0) ||
            (op == OP_MOD && (s64 == 64'd0 || trunc32(s64) == 32'd0))) begin
          err_next = err | ErrDiv0;
          state_next = ST_EOLRD;
        end else begin
          if (sp != '0) begin
            sp_next = sp - PtrW'(1);
            rgt_ok_next = 1'b1;
          end else begin
            rgt_ok_next = 1'b0;
            err_next = err | ErrUnder;
          end
          state_next = ST_LATCH;
        end
      end
      // left operand ready; add and subtract finish here, others set up serial unit
      ST_LATCH: begin
        lft_next = rgt_ok ? rd_data : 64'd0;
        s64 = rgt_ok ? rd_data : 64'd0;
        acc_next = '0;
        ovf_next = 1'b0;
        unique case (op)
          OP_ADD: begin
            res_next = s64 + rgt;
            if (s64[63] == rgt[63] && res_next[63] != s64[63])
              res_next = s64[63] ? QMin : QMax;
            state_next = ST_PUSH;
          end
          OP_SUB: begin
            res_next = s64 - rgt;
            if (s64[63] != rgt[63] && res_next[63] != s64[63])
              res_next = s64[63] ? QMin : QMax;
            state_next = ST_PUSH;
          end
          OP_MUL: begin
            sh_next = mag64(s64);
            dvs_next = mr;
            cnt_next = (CntW+1)'(64);
            state_next = ST_SERIAL;
          end
          OP_DIV: begin
            sh_next = mag64(s64);
            dvs_next = mr;
            cnt_next = (CntW+1)'(96);
            state_next = ST_SERIAL;
          end
          default: begin
            sh_next = {trunc32(s64), 32'd0};
            dvs_next = {32'd0, td};
            cnt_next = (CntW+1)'(32);
            state_next = ST_SERIAL;
          end
        endcase
      end
      // one bit per cycle
      ST_SERIAL: begin
        if (op == OP_MUL) begin
          // LSB-first shift-add: {acc,sh} is 128-bit product
          sum65 = {1'b0, acc} + (sh[0] ? {1'b0, dvs} : 65'd0);
          acc_next = sum65[64:1];
          sh_next = {sum65[0], sh[63:1]};
        end else begin
          // restoring division; sh supplies dividend bits then collects q
          rem65 = {acc, sh[63]};
          if (op == OP_DIV && cnt <= (CntW+1)'(32)) rem65 = {acc, 1'b0};
          if (rem65 >= {1'b0, dvs}) begin
            rem65 = rem65 - {1'b0, dvs};
            if (op == OP_DIV && cnt <= (CntW+1)'(32)) begin
              if (sh[63]) ovf_next = 1'b1;
              sh_next = {sh[62:0], 1'b1};
            end else begin
              sh_next = {sh[62:0], 1'b0};
            end
          end else begin
            if (op == OP_DIV && cnt <= (CntW+1)'(32)) begin
              if (sh[63]) ovf_next = 1'b1;
            end
            sh_next = {sh[62:0], 1'b0};
          end
          // quotient bits of divide steps while cnt is above 32 shift into sh LSB
          if (op == OP_DIV && cnt > (CntW+1)'(32)) begin
            sh_next[0] = (rem65 != {acc, sh[63]});
          end
          acc_next = rem65[63:0];
        end
        cnt_next = cnt - (CntW+1)'(1);
        if (cnt == (CntW+1)'(1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        unique case (op)
          OP_MUL: res_next = sat64(lft[63] != rgt[63], acc[63:32] != 32'd0,
                                   {acc[31:0], sh[63:32]});
          OP_DIV: res_next = sat64(lft[63] != rgt[63], ovf, sh);
          default: res_next = acc[31] ? QMax : {acc[31:0], 32'd0};
        endcase
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (sp < PtrW'(StackDepth)) begin
          wr_en = 1'b1;
          sp_next = sp + PtrW'(1);
        end else begin
          err_next = err | ErrOver;
        end
        state_next = ST_EOLRD;
      end
      ST_EOLRD: begin
        if (eol) begin
          if (sp != '0) begin
            sp_next = sp - PtrW'(1);
            rv_ok_next = 1'b1;
          end else begin
            rv_ok_next = 1'b0;
            err_next = err | ErrUnder;
          end
          state_next = ST_EOLWAIT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_EOLWAIT: begin
        rv_next = rv_ok ? rd_data : 64'd0;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign report_valid = done & eol;
  assign report_value = done ? rv : 64'd0;
  assign error_flags  = done ? err : 4'd0;
endmodule
`default_nettype wire

// ===== hw/rtl/rpn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rpn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        report_valid,
  input wire logic [63:0] report_value,
  input wire logic [3:0]  error_flags
);
  // a word is accepted only when idle, so busy follows
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");
  // result strobe comes only while busy
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");
  // block frees up right after the result
  a_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
  // report only with the strobe
  a_rep: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> done) else $error("stray report");
  // quiet result ports between results
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> (report_value == 64'd0 && error_flags == 4'd0))
    else $error("result ports not quiet");
endmodule

bind rpn_stack_calculator_top rpn_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .report_valid(report_valid), .report_value(report_value),
  .error_flags(error_flags)
);
`default_nettype wire
